>>> src/csp_pkg.sv
// Shared types and constants for the closest subsequence pair search unit.
// No dependencies; used by every module of the block.
`default_nettype none

package csp_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int ADDR_W      = 12;          // index into the sample store
    localparam int CNT_W       = 13;          // sample count, holds MAX_SAMPLES itself
    localparam int SAMPLE_W    = 16;
    localparam int DIST_W      = 44;
    localparam int LEN_W       = 11;
    localparam int POS_W       = 12;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int CMP_W       = 14;          // room for s + 1 + lag + L
    localparam int OUT_DATA_W  = 72;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd64;

    typedef enum logic [2:0] {
        OP_START,   // reset the best pair
        OP_CLR,     // clear the running sum for a new lag
        OP_ADD,     // add one squared difference
        OP_SUB,     // subtract one squared difference
        OP_CMP,     // compare running sum against the best
        OP_DONE     // publish the result
    } op_kind_t;

    typedef struct packed {
        logic             valid;
        op_kind_t         kind;
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] lag;
    } op_t;

    typedef struct packed {
        logic busy;         // ops in flight or a result waiting
    } acc_stat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_LAG,
        ST_SUM,
        ST_CMP,
        ST_SUB,
        ST_ADD,
        ST_DONE
    } seq_state_t;

endpackage

`default_nettype wire

>>> src/closest_subsequence_pair_search_unit.sv
// Closest subsequence pair search: top level joining the sequencer,
// sample store and datapath. Depends on csp_pkg, csp_store, csp_seq, csp_acc.
`default_nettype none

// Samples are taken one item per cycle and written to a 4096-entry store;
// samples past the 4096th are dropped. The item with s_tlast high starts the
// search, during which s_tready is low. The search issues one store access
// per cycle (two read ports) and tries each lag from L to n - L; with
// n < 2L no lag is tried and the no-pair result is given. The result leaves
// through an output register, and samples of the next series are accepted
// while it waits; the next search starts once it has been taken.
// window_length is to be written through cfg_data only while idle; the
// block itself does not enforce this.
module closest_subsequence_pair_search_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [15:0]                        s_tdata,    // [15:0] sample
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [csp_pkg::OUT_DATA_W-1:0]    m_tdata,    // [43:0] best_distance,
                                                          // [55:44] first_start,
                                                          // [67:56] second_start
    output logic                              m_tuser,    // [0] no_pair
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [csp_pkg::LEN_W-1:0]          cfg_data    // [10:0] window_length
);

    csp_pkg::op_t        op;
    csp_pkg::acc_stat_t  stat;
    logic                              wr_en;
    logic [csp_pkg::ADDR_W-1:0]        wr_addr;
    logic [csp_pkg::SAMPLE_W-1:0]      wr_data;
    logic [csp_pkg::ADDR_W-1:0]        rd_addr_a, rd_addr_b;
    logic [csp_pkg::SAMPLE_W-1:0]      rd_data_a, rd_data_b;

    csp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .op        (op),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    csp_store u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    csp_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> src/csp_store.sv
// Sample store: one write port, two registered read ports.
// Depends on csp_pkg.
`default_nettype none

module csp_store (
    input  wire                               clk,
    input  wire                               wr_en,
    input  wire [csp_pkg::ADDR_W-1:0]         wr_addr,
    input  wire [csp_pkg::SAMPLE_W-1:0]       wr_data,
    input  wire [csp_pkg::ADDR_W-1:0]         rd_addr_a,
    input  wire [csp_pkg::ADDR_W-1:0]         rd_addr_b,
    output logic [csp_pkg::SAMPLE_W-1:0]      rd_data_a,
    output logic [csp_pkg::SAMPLE_W-1:0]      rd_data_b
);

    logic [csp_pkg::SAMPLE_W-1:0] mem [csp_pkg::MAX_SAMPLES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> src/csp_seq.sv
// Sequencer: loads samples into the store, then issues one search op per
// cycle (store reads plus accumulate/compare commands). Depends on csp_pkg.
`default_nettype none

module csp_seq (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [15:0]                        s_tdata,    // sample
    input  wire                               s_tlast,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [csp_pkg::LEN_W-1:0]          cfg_data,   // window_length
    input  csp_pkg::acc_stat_t                stat,
    output csp_pkg::op_t                      op,
    output logic                              wr_en,
    output logic [csp_pkg::ADDR_W-1:0]        wr_addr,
    output logic [csp_pkg::SAMPLE_W-1:0]      wr_data,
    output logic [csp_pkg::ADDR_W-1:0]        rd_addr_a,
    output logic [csp_pkg::ADDR_W-1:0]        rd_addr_b
);

    csp_pkg::seq_state_t state_reg, state_next;
    logic [csp_pkg::LEN_W-1:0] len_reg;
    logic [csp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [csp_pkg::POS_W-1:0] lag_reg, lag_next;
    logic [csp_pkg::POS_W-1:0] s_reg, s_next;
    logic [csp_pkg::LEN_W-1:0] k_reg, k_next;

    logic [csp_pkg::LEN_W-1:0] len_eff;
    logic [csp_pkg::CMP_W-1:0] n_w, len_w, lag_w, s_w;
    logic                      pair_ok, slide_end, lag_more, not_full;

    assign len_eff  = (len_reg == '0) ? csp_pkg::LEN_W'(1) : len_reg;
    assign n_w      = csp_pkg::CMP_W'(cnt_reg);
    assign len_w    = csp_pkg::CMP_W'(len_eff);
    assign lag_w    = csp_pkg::CMP_W'(lag_reg);
    assign s_w      = csp_pkg::CMP_W'(s_reg);
    assign pair_ok  = n_w >= (len_w << 1);
    assign slide_end = (s_w + lag_w + len_w + csp_pkg::CMP_W'(1)) > n_w;
    assign lag_more  = (lag_w + len_w + csp_pkg::CMP_W'(1)) <= n_w;
    assign not_full  = cnt_reg < csp_pkg::CNT_W'(csp_pkg::MAX_SAMPLES);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csp_pkg::ST_LOAD;
            len_reg   <= csp_pkg::LEN_RESET;
            cnt_reg   <= '0;
            lag_reg   <= '0;
            s_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lag_reg   <= lag_next;
            s_reg     <= s_next;
            k_reg     <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= cfg_data;
            end
        end
    end

    // next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lag_next   = lag_reg;
        s_next     = s_reg;
        k_next     = k_reg;
        unique case (state_reg)
            csp_pkg::ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (not_full)
                    begin
                        cnt_next = cnt_reg + csp_pkg::CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next = csp_pkg::ST_START;
                    end
                end
            end
            csp_pkg::ST_START:
            begin
                if (!stat.busy)
                begin
                    lag_next   = csp_pkg::POS_W'(len_eff);
                    state_next = pair_ok ? csp_pkg::ST_LAG : csp_pkg::ST_DONE;
                end
            end
            csp_pkg::ST_LAG:
            begin
                k_next     = '0;
                state_next = csp_pkg::ST_SUM;
            end
            csp_pkg::ST_SUM:
            begin
                k_next = k_reg + csp_pkg::LEN_W'(1);
                if (k_reg == len_eff - csp_pkg::LEN_W'(1))
                begin
                    s_next     = '0;
                    state_next = csp_pkg::ST_CMP;
                end
            end
            csp_pkg::ST_CMP:
            begin
                if (slide_end)
                begin
                    if (lag_more)
                    begin
                        lag_next   = lag_reg + csp_pkg::POS_W'(1);
                        state_next = csp_pkg::ST_LAG;
                    end
                    else
                    begin
                        state_next = csp_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = csp_pkg::ST_SUB;
                end
            end
            csp_pkg::ST_SUB:
            begin
                state_next = csp_pkg::ST_ADD;
            end
            csp_pkg::ST_ADD:
            begin
                s_next     = s_reg + csp_pkg::POS_W'(1);
                state_next = csp_pkg::ST_CMP;
            end
            csp_pkg::ST_DONE:
            begin
                cnt_next   = '0;
                state_next = csp_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = csp_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs: input handshake, store access and op issue
    always_comb
    begin
        s_tready  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = cnt_reg[csp_pkg::ADDR_W-1:0];
        wr_data   = s_tdata[csp_pkg::SAMPLE_W-1:0];
        rd_addr_a = s_reg;
        rd_addr_b = s_reg + lag_reg;
        op.valid  = 1'b0;
        op.kind   = csp_pkg::OP_CLR;
        op.s      = s_reg;
        op.lag    = lag_reg;
        unique case (state_reg)
            csp_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
                wr_en    = s_tvalid && not_full;
            end
            csp_pkg::ST_START:
            begin
                op.valid = !stat.busy;
                op.kind  = csp_pkg::OP_START;
            end
            csp_pkg::ST_LAG:
            begin
                op.valid = 1'b1;
                op.kind  = csp_pkg::OP_CLR;
            end
            csp_pkg::ST_SUM:
            begin
                op.valid  = 1'b1;
                op.kind   = csp_pkg::OP_ADD;
                rd_addr_a = csp_pkg::ADDR_W'(k_reg);
                rd_addr_b = csp_pkg::ADDR_W'(k_reg) + lag_reg;
            end
            csp_pkg::ST_CMP:
            begin
                op.valid = 1'b1;
                op.kind  = csp_pkg::OP_CMP;
            end
            csp_pkg::ST_SUB:
            begin
                op.valid = 1'b1;
                op.kind  = csp_pkg::OP_SUB;
            end
            csp_pkg::ST_ADD:
            begin
                op.valid  = 1'b1;
                op.kind   = csp_pkg::OP_ADD;
                rd_addr_a = s_reg + csp_pkg::ADDR_W'(len_eff);
                rd_addr_b = s_reg + csp_pkg::ADDR_W'(len_eff) + lag_reg;
            end
            csp_pkg::ST_DONE:
            begin
                op.valid = 1'b1;
                op.kind  = csp_pkg::OP_DONE;
            end
            default:
            begin
                op.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/csp_acc.sv
// Datapath: squared difference of the two store reads, running sum,
// best-pair tracking and the output register. Depends on csp_pkg.
`default_nettype none

module csp_acc (
    input  wire                               clk,
    input  wire                               rst_n,
    input  csp_pkg::op_t                      op,
    input  wire [csp_pkg::SAMPLE_W-1:0]       rd_data_a,
    input  wire [csp_pkg::SAMPLE_W-1:0]       rd_data_b,
    output csp_pkg::acc_stat_t                stat,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [csp_pkg::OUT_DATA_W-1:0]    m_tdata,   // best_distance, first_start, second_start
    output logic                              m_tuser    // no_pair
);

    csp_pkg::op_t op1_reg, op2_reg, op3_reg;
    logic [csp_pkg::SAMPLE_W-1:0] absd2_reg;
    logic [csp_pkg::SQ_W-1:0]     sq3_reg;

    logic [csp_pkg::DIST_W-1:0]   run_reg, best_reg;
    logic [csp_pkg::POS_W-1:0]    first_reg, lag_reg;
    logic                         found_reg;

    logic                         out_valid_reg;
    logic [csp_pkg::DIST_W-1:0]   out_dist_reg;
    logic [csp_pkg::POS_W-1:0]    out_first_reg, out_second_reg;
    logic                         out_nopair_reg;

    logic signed [csp_pkg::SAMPLE_W:0] diff;
    logic [csp_pkg::SAMPLE_W:0]        diff_abs;

    assign diff     = {rd_data_a[csp_pkg::SAMPLE_W-1], rd_data_a}
                    - {rd_data_b[csp_pkg::SAMPLE_W-1], rd_data_b};
    assign diff_abs = diff[csp_pkg::SAMPLE_W] ? (-diff) : diff;

    // ops travel beside the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= '0;
            op2_reg <= '0;
            op3_reg <= '0;
        end
        else
        begin
            op1_reg <= op;
            op2_reg <= op1_reg;
            op3_reg <= op2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        absd2_reg    <= diff_abs[csp_pkg::SAMPLE_W-1:0];
        sq3_reg      <= absd2_reg * absd2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= '0;
            best_reg       <= '1;
            first_reg      <= '0;
            lag_reg        <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_dist_reg   <= '0;
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_nopair_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (op3_reg.valid)
            begin
                case (op3_reg.kind)
                    csp_pkg::OP_START:
                    begin
                        found_reg <= 1'b0;
                        best_reg  <= '1;
                        first_reg <= '0;
                        lag_reg   <= '0;
                    end
                    csp_pkg::OP_CLR:
                    begin
                        run_reg <= '0;
                    end
                    csp_pkg::OP_ADD:
                    begin
                        run_reg <= run_reg + csp_pkg::DIST_W'(sq3_reg);
                    end
                    csp_pkg::OP_SUB:
                    begin
                        run_reg <= run_reg - csp_pkg::DIST_W'(sq3_reg);
                    end
                    csp_pkg::OP_CMP:
                    begin
                        if (!found_reg || (run_reg < best_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= run_reg;
                            first_reg <= op3_reg.s;
                            lag_reg   <= op3_reg.lag;
                        end
                    end
                    csp_pkg::OP_DONE:
                    begin
                        // the sum tops out below 2^43, so no saturation is needed
                        out_valid_reg  <= 1'b1;
                        out_nopair_reg <= !found_reg;
                        out_dist_reg   <= found_reg ? best_reg : '0;
                        out_first_reg  <= found_reg ? first_reg : '0;
                        out_second_reg <= found_reg ? (first_reg + lag_reg) : '0;
                    end
                    default:
                    begin
                        run_reg <= run_reg;
                    end
                endcase
            end
        end
    end

    assign stat.busy = op1_reg.valid || op2_reg.valid || op3_reg.valid || out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_nopair_reg;
    assign m_tdata   = {{(csp_pkg::OUT_DATA_W - csp_pkg::DIST_W - 2 * csp_pkg::POS_W){1'b0}},
                        out_second_reg, out_first_reg, out_dist_reg};

`ifndef SYNTHESIS
    a_done_into_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        (op3_reg.valid && op3_reg.kind == csp_pkg::OP_DONE) |-> !out_valid_reg)
        else $error("result arrived while previous result still pending");

    a_nopair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[csp_pkg::DIST_W-1:0] == '0))
        else $error("no-pair result carries a nonzero distance");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(op3_reg.valid) && $past(op3_reg.kind) == csp_pkg::OP_DONE))
        else $error("result raised without a done op");

    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (op3_reg.valid && op3_reg.kind == csp_pkg::OP_CMP && found_reg)
        |=> (best_reg <= $past(best_reg)))
        else $error("best distance grew during a search");
`endif

endmodule

`default_nettype wire

>>> sim/tb_closest_subsequence_pair_search_unit.sv
// Self-checking testbench for closest_subsequence_pair_search_unit: streams sample series,
// predicts the closest window pair per series and checks every result item.
// Depends on csp_pkg and the RTL of the block only.
`default_nettype none

module tb_closest_subsequence_pair_search_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned DIST_SAT  = (64'd1 << csp_pkg::DIST_W) - 1;
    localparam int              PHASE_ITEMS = 150;

    typedef struct packed {
        logic [csp_pkg::DIST_W-1:0] distance;
        logic [csp_pkg::POS_W-1:0]  first;
        logic [csp_pkg::POS_W-1:0]  second;
        logic                       no_pair;
    } pair_result_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREMES,
        FILL_NARROW,
        FILL_MOTIF
    } fill_kind_t;

    class pair_search_scoreboard;
        logic signed [csp_pkg::SAMPLE_W-1:0] series [csp_pkg::MAX_SAMPLES];
        int unsigned                         series_len;
        logic [csp_pkg::LEN_W-1:0]           win_len;
        pair_result_t                        awaited_pairs [$];
        int                                  errors;

        function new();
            series_len = 0;
            win_len    = csp_pkg::LEN_RESET;
            errors     = 0;
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        function void set_window(input logic [csp_pkg::LEN_W-1:0] len);
            win_len = len;
        endfunction

        function int pending();
            return awaited_pairs.size();
        endfunction

        function longint unsigned sq_diff(input int unsigned a, input int unsigned b);
            longint d;
            d = longint'(series[a]) - longint'(series[b]);
            return longint'(d * d);
        endfunction

        // lag outer, start inner; only a strictly smaller sum replaces the best
        function pair_result_t find_closest_pair();
            int unsigned      n;
            int unsigned      len;
            int unsigned      lag;
            int unsigned      s;
            int unsigned      k;
            longint unsigned  run;
            longint unsigned  best;
            bit               found;
            pair_result_t     r;
            n     = series_len;
            len   = (win_len == 0) ? 1 : win_len;
            found = 0;
            best  = 0;
            r     = '0;
            if (n >= 2 * len)
            begin
                for (lag = len; lag + len <= n; lag++)
                begin
                    run = 0;
                    for (k = 0; k < len; k++)
                        run += sq_diff(k, k + lag);
                    for (s = 0; s + lag + len <= n; s++)
                    begin
                        if (!found || run < best)
                        begin
                            found    = 1;
                            best     = run;
                            r.first  = s[csp_pkg::POS_W-1:0];
                            r.second = csp_pkg::POS_W'(s + lag);
                        end
                        if (s + 1 + lag + len <= n)
                            run = run - sq_diff(s, s + lag) + sq_diff(s + len, s + len + lag);
                    end
                end
            end
            if (found)
                r.distance = (best > DIST_SAT) ? DIST_SAT[csp_pkg::DIST_W-1:0]
                                               : best[csp_pkg::DIST_W-1:0];
            else
                r.no_pair = 1'b1;
            return r;
        endfunction

        function void note_sample(input logic [csp_pkg::SAMPLE_W-1:0] raw, input logic last);
            if (series_len < csp_pkg::MAX_SAMPLES)
            begin
                series[series_len] = raw;
                series_len++;
            end
            if (last)
            begin
                awaited_pairs.push_back(find_closest_pair());
                series_len = 0;
            end
        endfunction

        task check_result(input logic [csp_pkg::DIST_W-1:0] distance,
                          input logic [csp_pkg::POS_W-1:0] first,
                          input logic [csp_pkg::POS_W-1:0] second, input logic no_pair);
            pair_result_t want;
            if (awaited_pairs.size() == 0)
            begin
                report("result item with nothing expected");
                return;
            end
            want = awaited_pairs.pop_front();
            if (distance !== want.distance)
                report($sformatf("best_distance %0d, expected %0d", distance, want.distance));
            if (first !== want.first)
                report($sformatf("first_start %0d, expected %0d", first, want.first));
            if (second !== want.second)
                report($sformatf("second_start %0d, expected %0d", second, want.second));
            if (no_pair !== want.no_pair)
                report($sformatf("no_pair %0b, expected %0b", no_pair, want.no_pair));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [csp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [csp_pkg::LEN_W-1:0]      cfg_data = '0;

    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 78;

    pair_search_scoreboard sb = new();

    closest_subsequence_pair_search_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_window(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[csp_pkg::DIST_W-1:0],
                                m_tdata[csp_pkg::DIST_W +: csp_pkg::POS_W],
                                m_tdata[csp_pkg::DIST_W+csp_pkg::POS_W +: csp_pkg::POS_W],
                                m_tuser);
        end
    end

    task automatic send_item(input logic [15:0] smp, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // holds the stream off until every expected result item has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [csp_pkg::LEN_W-1:0] len);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_series(input int unsigned len, input fill_kind_t fill);
        logic [15:0] motif [8];
        logic [15:0] smp;
        int unsigned i;
        foreach (motif[j])
            motif[j] = 16'($urandom);
        for (i = 0; i < len; i++)
        begin
            case (fill)
                FILL_RANDOM:
                    smp = 16'($urandom);
                FILL_EXTREMES:
                    case ($urandom_range(0, 3))
                        0:       smp = 16'h8000;
                        1:       smp = 16'h7FFF;
                        2:       smp = 16'h0000;
                        default: smp = 16'hFFFF;
                    endcase
                FILL_NARROW:
                    smp = 16'($urandom_range(0, 6) - 3);
                default:
                    // repeating pattern, lightly disturbed, gives exact and near matches
                    smp = motif[i % 8] ^ (($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 3))
                                                                      : 16'h0000);
            endcase
            send_item(smp, i == len - 1);
        end
    endtask

    task automatic send_list(input logic [15:0] vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    initial
    begin
        int unsigned win_plan [9];
        int unsigned p;
        int unsigned eff;
        int unsigned len;
        int unsigned sent;
        int unsigned series_no;

        win_plan = '{1, 3, 4, 2, 6, 0, 5, 8, 16};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // window length still at its reset value: the series is too short for a pair
        send_list('{16'h7FFF, 16'h8000, 16'h0000});
        write_window(csp_pkg::LEN_W'(1));
        send_list('{16'h8000, 16'h7FFF});
        send_list('{16'h1234});
        // zero length behaves as one; equal sums keep the earliest pair
        write_window(csp_pkg::LEN_W'(0));
        send_list('{16'd5, 16'd5, 16'd7, 16'd5});
        write_window(csp_pkg::LEN_W'(2));
        send_list('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
        send_list('{16'd3, 16'd3, 16'd3, 16'd3, 16'd3});

        // longest window on a short series, then a shorter window over a repeating pattern
        write_window(csp_pkg::LEN_W'(2047));
        send_series(5, FILL_RANDOM);
        write_window(csp_pkg::LEN_W'(40));
        send_series(80 + $urandom_range(0, 6), FILL_MOTIF);

        for (p = 0; p < 9; p++)
        begin
            write_window(csp_pkg::LEN_W'(win_plan[p]));
            case (p / 3)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            eff       = (win_plan[p] == 0) ? 1 : win_plan[p];
            sent      = 0;
            series_no = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (series_no == 3)
                    wait_drained();
                if ($urandom_range(0, 99) < 15)
                    len = $urandom_range(1, 2 * eff - 1);
                else
                    len = 2 * eff + $urandom_range(0, 24);
                send_series(len, fill_kind_t'($urandom_range(0, 3)));
                sent += len;
                series_no++;
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("** closest_subsequence_pair_search_unit: PASSED **");
        else
            $display("** closest_subsequence_pair_search_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TIMEOUT @%0t", $time);
        $display("** closest_subsequence_pair_search_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
src/csp_pkg.sv
src/csp_store.sv
src/csp_seq.sv
src/csp_acc.sv
src/closest_subsequence_pair_search_unit.sv
sim/tb_closest_subsequence_pair_search_unit.sv
